FILE: src/csrb_pkg.sv
// Shared types and constants of the chunked sample ring buffer.
`timescale 1ns / 1ps

package csrb_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int LEN_W     = 7;
   localparam int STATUS_W  = 3;
   localparam int FRAC_BITS = 15;
   localparam int QOUT_W    = SAMPLE_W + FRAC_BITS;
   localparam int FILL_W    = 11;
   localparam int CAP_W     = 11;
   localparam int CSR_IDX_W = 1;

   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_CAPACITY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE    = 1'd1;

   localparam logic [STATUS_W-1:0] ST_PUSHED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_SAMPLE    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_READY = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DRAINED   = 3'd4;

   typedef enum logic [1:0] {
      CTRL_IDLE,
      CTRL_MOD,
      CTRL_DRAIN
   } state_type;

   typedef struct packed {
      logic take_item;
      logic cfg_write;
      logic mod_run;
      logic load_sample;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic item_burst;
      logic burst_last;
      logic mod_done;
   } dp_status_type;

endpackage

FILE: src/csrb_ifs.sv
// Handshake interfaces for the request, response and register channels.
`timescale 1ns / 1ps

interface csrb_req_if;
   import csrb_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       cmd;
   logic signed [SAMPLE_W-1:0] sample_in;
   logic [LEN_W-1:0]           chunk_length;
   logic                       stream_ended;

   modport source (output valid, cmd, sample_in, chunk_length, stream_ended, input ready);
   modport sink (input valid, cmd, sample_in, chunk_length, stream_ended, output ready);
endinterface

interface csrb_rsp_if;
   import csrb_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic signed [QOUT_W-1:0] sample_out;
   logic                     last;
   logic [FILL_W-1:0]        fill_level;

   modport source (output valid, status, sample_out, last, fill_level, input ready);
   modport sink (input valid, status, sample_out, last, fill_level, output ready);
endinterface

interface csrb_cfg_if;
   import csrb_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CAP_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: src/csrb_ctrl.sv
// Controller state machine sequencing items, chunk delivery and position reduction.
`timescale 1ns / 1ps

module csrb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    csr_valid,
   input  logic [csrb_pkg::CSR_IDX_W-1:0] csr_index,
   output logic                    csr_ready,
   input  csrb_pkg::dp_status_type stat,
   output csrb_pkg::dp_cmd_type    cmd
);
   import csrb_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTRL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTRL_IDLE: begin
            if (csr_valid && csr_index == REG_CAPACITY) begin
               state_in = CTRL_MOD;
            end else if (req_valid && stat.out_free && stat.item_burst && !csr_valid) begin
               state_in = CTRL_DRAIN;
            end
         end
         CTRL_MOD: begin
            if (stat.mod_done) begin
               state_in = CTRL_IDLE;
            end
         end
         CTRL_DRAIN: begin
            if (stat.out_free && stat.burst_last) begin
               state_in = CTRL_IDLE;
            end
         end
         default: state_in = CTRL_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      csr_ready = 1'b0;
      case (state_ff)
         CTRL_IDLE: begin
            req_ready     = stat.out_free && !csr_valid;
            csr_ready     = 1'b1;
            cmd.take_item = req_valid && stat.out_free && !csr_valid;
            cmd.cfg_write = csr_valid;
         end
         CTRL_MOD: begin
            cmd.mod_run = 1'b1;
         end
         CTRL_DRAIN: begin
            cmd.load_sample = stat.out_free;
         end
         default: ;
      endcase
   end

endmodule

FILE: src/csrb_dp.sv
// Datapath: sample memory, ring pointers, position reduction unit and output register.
`timescale 1ns / 1ps

module csrb_dp #(
   parameter int DEPTH     = 1024,
   parameter int MAX_CHUNK = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  csrb_pkg::dp_cmd_type              cmd,
   output csrb_pkg::dp_status_type           stat,
   input  logic                              req_cmd,
   input  logic signed [csrb_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic [csrb_pkg::LEN_W-1:0]        req_chunk_length,
   input  logic                              req_stream_ended,
   input  logic [csrb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [csrb_pkg::CAP_W-1:0]        csr_data,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [csrb_pkg::STATUS_W-1:0]     rsp_status,
   output logic signed [csrb_pkg::QOUT_W-1:0] rsp_sample_out,
   output logic                              rsp_last,
   output logic [csrb_pkg::FILL_W-1:0]       rsp_fill_level
);
   import csrb_pkg::*;

   localparam int PW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int AW   = PW + 1;
   localparam int MCW  = $clog2(PW + 1);
   localparam int NW   = $clog2(MAX_CHUNK + 1);
   localparam int CMPW = (CW > LEN_W) ? CW : LEN_W;

   function automatic logic [CW-1:0] eff_cap(input logic [CAP_W-1:0] v);
      logic [CW-1:0] r;
      if (v == '0) begin
         r = CW'(1);
      end else if (32'(v) > DEPTH) begin
         r = CW'(DEPTH);
      end else begin
         r = CW'(v);
      end
      return r;
   endfunction

   function automatic logic signed [QOUT_W-1:0] to_q(input logic [SAMPLE_W-1:0] raw,
                                                     input logic unit);
      logic signed [QOUT_W-1:0] q;
      if (unit) begin
         q = {{FRAC_BITS{raw[SAMPLE_W-1]}}, raw};
      end else begin
         q = {raw, {FRAC_BITS{1'b0}}};
      end
      return q;
   endfunction

   logic [SAMPLE_W-1:0] mem [DEPTH];

   logic [CW-1:0]   count_ff, count_in;
   logic [PW-1:0]   pos_ff, pos_in;
   logic [PW-1:0]   raw_ff, raw_in;
   logic [CW-1:0]   cap_ff, cap_in;
   logic            scale_ff, scale_in;
   logic [CW-1:0]   rem_ff, rem_in;
   logic [PW-1:0]   shift_ff, shift_in;
   logic [MCW-1:0]  mcnt_ff, mcnt_in;
   logic [NW-1:0]   left_ff, left_in;
   logic [SAMPLE_W-1:0] rd_data_ff;

   logic                     out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]      out_status_ff, out_status_in;
   logic signed [QOUT_W-1:0] out_sample_ff, out_sample_in;
   logic                     out_last_ff, out_last_in;
   logic [FILL_W-1:0]        out_fill_ff, out_fill_in;

   logic [LEN_W-1:0]  want;
   logic              short_data;
   logic [CMPW-1:0]   n_wide;
   logic              is_read;
   logic              zero_len;
   logic              not_ready;
   logic              burst;
   logic              push_ok;
   logic              load_single;
   logic [STATUS_W-1:0] single_code;
   logic [CW-1:0]     count_after;
   logic [AW-1:0]     addr_sum;
   logic [AW-1:0]     addr_wrap;
   logic [PW-1:0]     wr_addr;
   logic [AW-1:0]     pos_inc;
   logic [PW-1:0]     pos_next;
   logic [CW:0]       mod_t;
   logic [CW-1:0]     mod_step;
   logic              rd_en;
   logic              wr_en;
   logic [PW-1:0]     rd_addr;

   always_comb begin
      want = (req_chunk_length > LEN_W'(MAX_CHUNK)) ? LEN_W'(MAX_CHUNK) : req_chunk_length;
      short_data  = CMPW'(want) > CMPW'(count_ff);
      n_wide      = short_data ? CMPW'(count_ff) : CMPW'(want);
      is_read     = req_cmd == CMD_READ;
      zero_len    = req_chunk_length == '0;
      not_ready   = short_data && !req_stream_ended;
      burst       = is_read && !zero_len && !not_ready && (n_wide != '0);
      push_ok     = count_ff < cap_ff;
      load_single = cmd.take_item && !(is_read && zero_len) && !burst;
      if (!is_read) begin
         single_code = push_ok ? ST_PUSHED : ST_FULL;
      end else begin
         single_code = not_ready ? ST_NOT_READY : ST_DRAINED;
      end
      count_after = (!is_read && push_ok) ? count_ff + CW'(1) : count_ff;

      addr_sum  = AW'(pos_ff) + AW'(count_ff);
      addr_wrap = (addr_sum >= AW'(cap_ff)) ? addr_sum - AW'(cap_ff) : addr_sum;
      wr_addr   = addr_wrap[PW-1:0];

      pos_inc  = AW'(pos_ff) + AW'(1);
      pos_next = (pos_inc == AW'(cap_ff)) ? '0 : pos_inc[PW-1:0];

      mod_t    = {rem_ff, shift_ff[PW-1]};
      mod_step = (mod_t >= (CW + 1)'(cap_ff)) ? CW'(mod_t - (CW + 1)'(cap_ff)) : CW'(mod_t);

      wr_en   = cmd.take_item && !is_read && push_ok;
      rd_en   = (cmd.take_item && burst) || (cmd.load_sample && left_ff > NW'(1));
      rd_addr = cmd.load_sample ? pos_next : pos_ff;
   end

   always_comb begin
      count_in      = count_ff;
      pos_in        = pos_ff;
      raw_in        = raw_ff;
      cap_in        = cap_ff;
      scale_in      = scale_ff;
      rem_in        = rem_ff;
      shift_in      = shift_ff;
      mcnt_in       = mcnt_ff;
      left_in       = left_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_sample_in = out_sample_ff;
      out_last_in   = out_last_ff;
      out_fill_in   = out_fill_ff;

      if (cmd.cfg_write) begin
         case (csr_index)
            REG_CAPACITY: begin
               cap_in   = eff_cap(csr_data);
               rem_in   = '0;
               shift_in = raw_ff;
               mcnt_in  = MCW'(PW);
            end
            REG_SCALE: scale_in = csr_data[0];
            default: ;
         endcase
      end

      // The stored position is reduced modulo the new capacity one bit per cycle.
      if (cmd.mod_run) begin
         if (mcnt_ff != '0) begin
            rem_in   = mod_step;
            shift_in = shift_ff << 1;
            mcnt_in  = mcnt_ff - MCW'(1);
         end else begin
            pos_in = PW'(rem_ff);
         end
      end

      if (cmd.take_item) begin
         count_in = count_after;
         if (burst) begin
            left_in = NW'(n_wide);
         end
         if (load_single) begin
            out_valid_in  = 1'b1;
            out_status_in = single_code;
            out_sample_in = '0;
            out_last_in   = 1'b1;
            out_fill_in   = FILL_W'(count_after);
         end
      end

      if (cmd.load_sample) begin
         out_valid_in  = 1'b1;
         out_status_in = ST_SAMPLE;
         out_sample_in = to_q(rd_data_ff, scale_ff);
         out_last_in   = left_ff == NW'(1);
         out_fill_in   = FILL_W'(count_ff - CW'(1));
         count_in      = count_ff - CW'(1);
         pos_in        = pos_next;
         raw_in        = pos_next;
         left_in       = left_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_sample_in;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pos_ff       <= '0;
         raw_ff       <= '0;
         cap_ff       <= eff_cap(CAP_RESET);
         scale_ff     <= 1'b0;
         mcnt_ff      <= '0;
         left_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         raw_ff       <= raw_in;
         cap_ff       <= cap_in;
         scale_ff     <= scale_in;
         mcnt_ff      <= mcnt_in;
         left_ff      <= left_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      shift_ff      <= shift_in;
      out_status_ff <= out_status_in;
      out_sample_ff <= out_sample_in;
      out_last_ff   <= out_last_in;
      out_fill_ff   <= out_fill_in;
   end

   assign stat.out_free   = !out_valid_ff || rsp_ready;
   assign stat.item_burst = burst;
   assign stat.burst_last = left_ff == NW'(1);
   assign stat.mod_done   = mcnt_ff == '0;

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_sample_out = out_sample_ff;
   assign rsp_last       = out_last_ff;
   assign rsp_fill_level = out_fill_ff;

endmodule

FILE: src/chunked_sample_ring_buffer.sv
// Top level of the chunked sample ring buffer: controller, datapath and channels.
// A push or single-status request gives its response word in the cycle after acceptance.
// A chunk of n samples gives its first word through the memory read register and the output
// register, then one word per cycle while the response side is ready; the next request is taken after the last.
// A capacity write reduces the read position modulo the new capacity one bit per cycle.
// Synchronous reset empties the ring, sets capacity 1024 and integer output; memory is kept.
`timescale 1ns / 1ps

module chunked_sample_ring_buffer #(
   parameter int DEPTH     = 1024,
   parameter int MAX_CHUNK = 64
) (
   input logic       clock,
   input logic       reset,
   csrb_req_if.sink  req_bus,
   csrb_rsp_if.source rsp_bus,
   csrb_cfg_if.sink  csr_bus
);
   import csrb_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type stat;

   csrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .csr_valid (csr_bus.valid),
      .csr_index (csr_bus.index),
      .csr_ready (csr_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   csrb_dp #(
      .DEPTH     (DEPTH),
      .MAX_CHUNK (MAX_CHUNK)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_cmd          (req_bus.cmd),
      .req_sample_in    (req_bus.sample_in),
      .req_chunk_length (req_bus.chunk_length),
      .req_stream_ended (req_bus.stream_ended),
      .csr_index        (csr_bus.index),
      .csr_data         (csr_bus.data),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .rsp_status       (rsp_bus.status),
      .rsp_sample_out   (rsp_bus.sample_out),
      .rsp_last         (rsp_bus.last),
      .rsp_fill_level   (rsp_bus.fill_level)
   );

endmodule

FILE: src/csrb_props.sv
// Port-level assertions for the chunked sample ring buffer and their binding.
`timescale 1ns / 1ps

module csrb_props (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [csrb_pkg::STATUS_W-1:0]      rsp_status,
   input logic signed [csrb_pkg::QOUT_W-1:0] rsp_sample_out,
   input logic                               rsp_last,
   input logic [csrb_pkg::FILL_W-1:0]        rsp_fill_level
);
   import csrb_pkg::*;

   // A stalled response word keeps its contents.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable({rsp_status, rsp_sample_out, rsp_last, rsp_fill_level}))
      else $error("response word changed while stalled");

   // Status words carry no sample and always close their request.
   a_status_word : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_SAMPLE |-> rsp_last && rsp_sample_out == '0)
      else $error("status word with sample data or without last");

   // No new request is taken while a chunk is still being delivered.
   a_chunk_blocks : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_SAMPLE && !rsp_last |-> !req_ready)
      else $error("request accepted in the middle of a chunk");

   // Within a chunk the next sample follows at once, one fewer stored.
   a_chunk_stream : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_status == ST_SAMPLE && !rsp_last |=>
         rsp_valid && rsp_status == ST_SAMPLE &&
         rsp_fill_level == $past(rsp_fill_level) - FILL_W'(1))
      else $error("chunk sample missing or fill level not decremented");

endmodule

bind chunked_sample_ring_buffer csrb_props u_props (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_status     (rsp_bus.status),
   .rsp_sample_out (rsp_bus.sample_out),
   .rsp_last       (rsp_bus.last),
   .rsp_fill_level (rsp_bus.fill_level)
);

FILE: sim/csrb_ring_checker.sv
// Checker for the chunked sample ring buffer: predicts every response word and compares it.
`timescale 1ns / 1ps

module csrb_ring_checker #(
   parameter int DEPTH     = 1024,
   parameter int MAX_CHUNK = 64
) (
   input  logic clock,
   input  logic reset,
   csrb_req_if  req_mon,
   csrb_rsp_if  rsp_mon,
   csrb_cfg_if  csr_mon,
   output int   mismatches,
   output int   words_due,
   output int   ring_fill
);
   import csrb_pkg::*;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [QOUT_W-1:0] sample;
      logic                     last;
      logic [FILL_W-1:0]        fill;
   } rsp_word_type;

   logic [SAMPLE_W-1:0] ring_mem [DEPTH];
   int                  rd_pos;
   logic [CAP_W-1:0]    cap_reg;
   logic                scale_reg;
   rsp_word_type        due_q [$];

   function automatic int slots_in_use();
      if (cap_reg == 0) return 1;
      if (cap_reg > DEPTH) return DEPTH;
      return int'(cap_reg);
   endfunction

   function automatic rsp_word_type status_word(input logic [STATUS_W-1:0] st);
      rsp_word_type w;
      w.status = st;
      w.sample = '0;
      w.last   = 1'b1;
      w.fill   = ring_fill[FILL_W-1:0];
      return w;
   endfunction

   task automatic predict_item(input logic cmd, input logic [SAMPLE_W-1:0] smp,
                               input logic [LEN_W-1:0] len, input logic ended);
      int                  cap;
      int                  take;
      int                  pos;
      logic [SAMPLE_W-1:0] raw;
      rsp_word_type        w;
      cap = slots_in_use();
      if (cmd == CMD_PUSH) begin
         if (ring_fill >= cap) begin
            due_q.push_back(status_word(ST_FULL));
         end else begin
            ring_mem[((rd_pos % cap) + ring_fill) % cap] = smp;
            ring_fill++;
            due_q.push_back(status_word(ST_PUSHED));
         end
      end else if (len != 0) begin
         take = (len > MAX_CHUNK) ? MAX_CHUNK : int'(len);
         if (take > ring_fill && !ended) begin
            due_q.push_back(status_word(ST_NOT_READY));
         end else begin
            if (take > ring_fill) take = ring_fill;
            if (take == 0) due_q.push_back(status_word(ST_DRAINED));
            for (int i = 0; i < take; i++) begin
               pos = rd_pos % cap;
               raw = ring_mem[pos];
               rd_pos = (pos + 1) % cap;
               ring_fill--;
               w.status = ST_SAMPLE;
               w.sample = scale_reg ? {{FRAC_BITS{raw[SAMPLE_W-1]}}, raw}
                                    : {raw, {FRAC_BITS{1'b0}}};
               w.last   = (i == take - 1);
               w.fill   = ring_fill[FILL_W-1:0];
               due_q.push_back(w);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      if (reset) begin
         rd_pos    = 0;
         ring_fill = 0;
         cap_reg   = CAP_RESET;
         scale_reg = 1'b0;
         due_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.status = rsp_mon.status;
            got.sample = rsp_mon.sample_out;
            got.last   = rsp_mon.last;
            got.fill   = rsp_mon.fill_level;
            if (due_q.size() == 0) begin
               $display("%0t: unexpected word: status %0d sample %0d last %0d fill %0d",
                        $time, got.status, got.sample, got.last, got.fill);
               mismatches++;
            end else begin
               want = due_q.pop_front();
               if (got !== want) begin
                  $display({"%0t: expected status %0d sample %0d last %0d fill %0d,",
                            " got status %0d sample %0d last %0d fill %0d"}, $time,
                           want.status, want.sample, want.last, want.fill,
                           got.status, got.sample, got.last, got.fill);
                  mismatches++;
               end
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == REG_CAPACITY) cap_reg = csr_mon.data;
            else if (csr_mon.index == REG_SCALE) scale_reg = csr_mon.data[0];
         end
         if (req_mon.valid && req_mon.ready)
            predict_item(req_mon.cmd, req_mon.sample_in, req_mon.chunk_length,
                         req_mon.stream_ended);
      end
      words_due = due_q.size();
   end

endmodule

FILE: sim/tb_chunked_sample_ring_buffer.sv
// Testbench top for the chunked sample ring buffer: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module tb_chunked_sample_ring_buffer;
   import csrb_pkg::*;

   localparam int IDLE_PCT    = 26;
   localparam int SETTLE      = 24;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASES      = 8;

   logic clock;
   logic reset;
   logic steady;
   int   mismatches;
   int   words_due;
   int   ring_fill;
   int   stall_cycles;

   int phase_cap   [PHASES] = '{0, 1, 2047, 8, 37, 1024, 3, 2};
   int phase_scale [PHASES] = '{0, 1, 0, 1, 0, 1, 0, 1};
   int phase_items [PHASES] = '{45, 35, 65, 55, 65, 55, 45, 55};
   int phase_push  [PHASES] = '{50, 50, 65, 55, 60, 55, 50, 50};

   csrb_req_if req_bus ();
   csrb_rsp_if rsp_bus ();
   csrb_cfg_if csr_bus ();

   chunked_sample_ring_buffer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   csrb_ring_checker ring_mon (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_mon    (csr_bus),
      .mismatches (mismatches),
      .words_due  (words_due),
      .ring_fill  (ring_fill)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_bus.valid && csr_bus.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("tb_chunked_sample_ring_buffer: done, errors");
      $finish;
   end

   // Every task below is entered and left at a falling edge.
   task automatic send_item(input logic cmd, input logic [SAMPLE_W-1:0] smp,
                            input logic [LEN_W-1:0] len, input logic ended);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid        = 1'b1;
      req_bus.cmd          = cmd;
      req_bus.sample_in    = smp;
      req_bus.chunk_length = len;
      req_bus.stream_ended = ended;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic send_random(input int push_pct, output bit counted);
      logic             cmd;
      logic [LEN_W-1:0] len;
      int               pick;
      cmd  = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_READ;
      pick = $urandom_range(99);
      if (pick < 5) len = '0;
      else if (pick < 10) len = LEN_W'($urandom_range(127, 65));
      else if (pick < 25) len = LEN_W'($urandom_range(64, 17));
      else len = LEN_W'($urandom_range(16, 1));
      counted = (cmd == CMD_PUSH) || (len != 0);
      send_item(cmd, SAMPLE_W'($urandom), len, $urandom_range(99) < 30);
   endtask

   task automatic settle();
      req_bus.valid = 1'b0;
      while (words_due != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = CAP_W'(value);
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic drain_ring();
      while (ring_fill != 0) send_item(CMD_READ, SAMPLE_W'($urandom), LEN_W'(64), 1'b1);
      settle();
   endtask

   initial begin
      bit counted;
      int done;
      reset                = 1'b1;
      steady               = 1'b0;
      req_bus.valid        = 1'b0;
      req_bus.cmd          = CMD_PUSH;
      req_bus.sample_in    = '0;
      req_bus.chunk_length = '0;
      req_bus.stream_ended = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = REG_CAPACITY;
      csr_bus.data         = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty ring: not ready, drained, and a zero-length read that gives nothing.
      send_item(CMD_READ, 16'h1234, 7'd1, 1'b0);
      send_item(CMD_READ, 16'h4321, 7'd5, 1'b1);
      send_item(CMD_READ, 16'hFFFF, 7'd0, 1'b1);
      send_item(CMD_PUSH, 16'h7FFF, 7'd127, 1'b1);
      send_item(CMD_PUSH, 16'h8000, 7'd0, 1'b0);
      send_item(CMD_PUSH, 16'h0000, 7'd64, 1'b1);
      send_item(CMD_PUSH, 16'hFFFF, 7'd1, 1'b0);
      send_item(CMD_PUSH, 16'h0001, 7'd3, 1'b1);
      send_item(CMD_PUSH, 16'h5555, 7'd42, 1'b0);
      send_item(CMD_PUSH, 16'hAAAA, 7'd85, 1'b1);
      send_item(CMD_READ, 16'h0000, 7'd3, 1'b0);
      send_item(CMD_READ, 16'hFFFF, 7'd10, 1'b0);
      // An oversized chunk saturates and, with the stream ended, returns the short remainder.
      send_item(CMD_READ, 16'h8001, 7'd127, 1'b1);
      send_item(CMD_READ, 16'h7FFE, 7'd64, 1'b1);

      settle();
      write_reg(REG_CAPACITY, 2);
      write_reg(REG_SCALE, 1);
      send_item(CMD_PUSH, 16'h8000, 7'd0, 1'b0);
      send_item(CMD_PUSH, 16'h7FFF, 7'd127, 1'b1);
      send_item(CMD_PUSH, 16'h1111, 7'd1, 1'b0);
      send_item(CMD_READ, 16'h0000, 7'd2, 1'b0);
      send_item(CMD_PUSH, 16'hFFFF, 7'd9, 1'b1);
      send_item(CMD_READ, 16'h2222, 7'd127, 1'b0);
      send_item(CMD_READ, 16'h3333, 7'd127, 1'b1);
      send_item(CMD_READ, 16'h4444, 7'd0, 1'b0);

      // Capacity only changes with the ring empty, so no unwritten slot is ever read.
      for (int p = 0; p < PHASES; p++) begin
         steady = 1'b0;
         drain_ring();
         write_reg(REG_CAPACITY, phase_cap[p]);
         write_reg(REG_SCALE, phase_scale[p]);
         steady = (p == 3);
         done = 0;
         while (done < phase_items[p]) begin
            send_random(phase_push[p], counted);
            if (counted) done++;
         end
      end

      steady = 1'b0;
      settle();
      if (mismatches == 0 && words_due == 0) begin
         $display("tb_chunked_sample_ring_buffer: done, clean");
      end else begin
         $display("tb_chunked_sample_ring_buffer: done, errors");
      end
      $finish;
   end

endmodule
